### hw/rtl/svg_pkg.sv
package svg_pkg;

   // field widths
   localparam int FRAC_BITS = 16;
   localparam int RADIUS_W = 24;
   localparam int COUNT_W  = 11;
   localparam int RING_W   = 11;
   localparam int SEG_W    = 10;
   localparam int POS_W    = 25;
   localparam int NORM_W   = FRAC_BITS + 2;
   localparam int MAX_SEGMENTS = 1024;

   // internal widths
   localparam int PHASE_W = 32;
   localparam int DEN_W   = 12;
   localparam int TRIG_W  = 33;
   localparam int CORDIC_STEPS = 30;

   // register indexes
   localparam logic [1:0] REG_RADIUS   = 2'd0;
   localparam logic [1:0] REG_RINGS    = 2'd1;
   localparam logic [1:0] REG_SEGMENTS = 2'd2;

   // fixed point constants
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [TRIG_W-1:0] CORDIC_X0 = 33'd652032874;
   localparam logic [TRIG_W-1:0] Q30_ONE = 33'd1073741824;
   localparam logic signed [POS_W-1:0] POS_LIMIT = 25'sd16777215;
   localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(1 << FRAC_BITS);

   // per-transaction sideband
   typedef struct packed {
      logic bad;
      logic pole;
      logic south;
   } meta_type;

   // arctangent table in Q30
   function automatic logic [TRIG_W-1:0] atan_q30(input int step);
      logic [TRIG_W-1:0] v;
      case (step)
         0: v = 33'd843314857;
         1: v = 33'd497837829;
         2: v = 33'd263043837;
         3: v = 33'd133525159;
         4: v = 33'd67021687;
         5: v = 33'd33543516;
         6: v = 33'd16775851;
         7: v = 33'd8388437;
         8: v = 33'd4194283;
         9: v = 33'd2097149;
         default: v = TRIG_W'(33'd1 << (30 - step));
      endcase
      return v;
   endfunction

endpackage

### hw/rtl/svg_div.sv
module svg_div (
   input  logic clock,
   input  logic advance,
   input  logic [svg_pkg::RING_W-1:0] num_hi,
   input  logic [svg_pkg::DEN_W-1:0] num_lo,
   input  logic [svg_pkg::DEN_W-1:0] den,
   output logic [svg_pkg::PHASE_W-1:0] quo
);
   localparam int STEPS = svg_pkg::PHASE_W;
   localparam int DW = svg_pkg::DEN_W;

   logic [DW-1:0] rem_ff [STEPS];
   logic [STEPS-1:0] quo_ff [STEPS];
   logic [STEPS-1:0] lo_ff [STEPS];

   // one quotient bit per stage, restoring division
   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [DW-1:0] rem_prev;
      logic [STEPS-1:0] quo_prev;
      logic [STEPS-1:0] lo_prev;
      logic [DW:0] trial_in;
      logic take;
      if (j == 0) begin : g_first
         assign rem_prev = DW'(num_hi);
         assign quo_prev = '0;
         assign lo_prev  = STEPS'(num_lo);
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign quo_prev = quo_ff[j-1];
         assign lo_prev  = lo_ff[j-1];
      end
      assign trial_in = {rem_prev, lo_prev[STEPS-1-j]};
      assign take = trial_in >= {1'b0, den};
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j] <= take ? DW'(trial_in - {1'b0, den}) : trial_in[DW-1:0];
            quo_ff[j] <= {quo_prev[STEPS-2:0], take};
            lo_ff[j]  <= lo_prev;
         end
      end
   end

   assign quo = quo_ff[STEPS-1];
endmodule

### hw/rtl/svg_cordic.sv
module svg_cordic (
   input  logic clock,
   input  logic advance,
   input  logic [svg_pkg::PHASE_W-1:0] phase,
   output logic signed [svg_pkg::TRIG_W-1:0] sin_q,
   output logic signed [svg_pkg::TRIG_W-1:0] cos_q
);
   localparam int N = svg_pkg::CORDIC_STEPS;
   localparam int TW = svg_pkg::TRIG_W;

   logic signed [TW-1:0] x_ff [N+1];
   logic signed [TW-1:0] y_ff [N+1];
   logic signed [TW-1:0] z_ff [N+1];
   logic [1:0] quad_ff [N+1];
   logic zero_ff [N+1];
   logic signed [TW-1:0] sin_ff, cos_ff;
   logic [60:0] angle_prod;

   // phase to radians in Q30
   assign angle_prod = phase[29:0] * svg_pkg::HALF_PI_Q30;
   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= svg_pkg::CORDIC_X0;
         y_ff[0]    <= '0;
         z_ff[0]    <= TW'(angle_prod[60:30]);
         quad_ff[0] <= phase[31:30];
         zero_ff[0] <= phase[29:0] == '0;
      end
   end

   // rotation steps, one per stage
   for (genvar i = 0; i < N; i++) begin : g_rot
      logic signed [TW-1:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!z_ff[i][TW-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - signed'(svg_pkg::atan_q30(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + signed'(svg_pkg::atan_q30(i));
            end
            quad_ff[i+1] <= quad_ff[i];
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   // quadrant fold
   logic signed [TW-1:0] xs, ys;
   assign xs = zero_ff[N] ? signed'(svg_pkg::Q30_ONE) : x_ff[N];
   assign ys = zero_ff[N] ? '0 : y_ff[N];
   always_ff @(posedge clock) begin
      if (advance) begin
         case (quad_ff[N])
            2'd0: begin sin_ff <= ys;  cos_ff <= xs;  end
            2'd1: begin sin_ff <= xs;  cos_ff <= -ys; end
            2'd2: begin sin_ff <= -ys; cos_ff <= -xs; end
            default: begin sin_ff <= -xs; cos_ff <= ys; end
         endcase
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;
endmodule

### hw/rtl/sphere_vertex_generator.sv
// sphere vertex generator: one uv-sphere vertex per request transaction
// req channel carries ring_number and segment_number; rsp channel returns
// position (signed Q8.16), unit normal (signed Q1.16) and bad_request
// handshake: a transaction moves when valid is high and stall is low
// the apb port sets radius (0x0), ring_count (0x4) and segment_count (0x8)
// registers may only change while no transaction is in flight
// the pipeline takes one request per cycle while req_stall is low: an input
// register, a 32-stage phase divider, a 32-stage cordic and four multiply
// and rounding stages
// every stage advances together; while a response is held by rsp_stall
// the whole pipeline freezes and req_stall is raised, nothing is lost
// synchronous reset clears all valid bits and loads radius 1.0, 16 rings,
// 32 segments
module sphere_vertex_generator (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [svg_pkg::RING_W-1:0] req_ring_number,
   input  logic [svg_pkg::SEG_W-1:0] req_segment_number,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [svg_pkg::POS_W-1:0] rsp_pos_x,
   output logic signed [svg_pkg::POS_W-1:0] rsp_pos_y,
   output logic signed [svg_pkg::POS_W-1:0] rsp_pos_z,
   output logic signed [svg_pkg::NORM_W-1:0] rsp_norm_x,
   output logic signed [svg_pkg::NORM_W-1:0] rsp_norm_y,
   output logic signed [svg_pkg::NORM_W-1:0] rsp_norm_z,
   output logic rsp_bad_request,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [3:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   localparam int LAT = 69;
   localparam int TW = svg_pkg::TRIG_W;
   localparam int CW = svg_pkg::COUNT_W;
   localparam int POS_W_L = TW + 25;

   logic [svg_pkg::RADIUS_W-1:0] radius_ff;
   logic [CW-1:0] rings_ff, segs_cfg_ff;
   logic [CW-1:0] segs_eff;
   logic advance;

   logic vld_ff [LAT];
   svg_pkg::meta_type meta_ff [LAT-1];
   svg_pkg::meta_type meta_in;

   // register port
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= 24'd65536;
         rings_ff    <= 11'd16;
         segs_cfg_ff <= 11'd32;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            svg_pkg::REG_RADIUS:   radius_ff <= pwdata[23:0];
            svg_pkg::REG_RINGS:    rings_ff <= pwdata[CW-1:0];
            svg_pkg::REG_SEGMENTS: segs_cfg_ff <= pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         svg_pkg::REG_RADIUS:   prdata = 32'(radius_ff);
         svg_pkg::REG_RINGS:    prdata = 32'(rings_ff);
         svg_pkg::REG_SEGMENTS: prdata = 32'(segs_cfg_ff);
         default:               prdata = '0;
      endcase
   end

   // flow control, the whole pipe holds while a response waits
   assign advance = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !advance;
   assign segs_eff = (int'(segs_cfg_ff) > svg_pkg::MAX_SEGMENTS) ?
                     CW'(svg_pkg::MAX_SEGMENTS) : segs_cfg_ff;

   // request decode
   always_comb begin
      meta_in = '0;
      if (req_ring_number == '0) begin
         meta_in.pole = 1'b1;
      end else if (req_ring_number == rings_ff + 11'd1) begin
         meta_in.pole = 1'b1;
         meta_in.south = 1'b1;
      end else if (req_ring_number > rings_ff ||
                   CW'(req_segment_number) >= segs_eff) begin
         meta_in.bad = 1'b1;
      end
   end

   logic [svg_pkg::RING_W-1:0] ring0_ff;
   logic [svg_pkg::SEG_W-1:0] seg0_ff;

   // valid and sideband travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) vld_ff[k] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         meta_ff[0] <= meta_in;
         for (int k = 1; k < LAT-1; k++) meta_ff[k] <= meta_ff[k-1];
         ring0_ff <= req_ring_number;
         seg0_ff  <= req_segment_number;
      end
   end

   // phase dividers: ring/(2*rings) and segment/segments turns, rounded
   logic [svg_pkg::PHASE_W-1:0] phase_t, phase_p;

   svg_div u_div_t (
      .clock(clock), .advance(advance),
      .num_hi(ring0_ff),
      .num_lo({1'b0, rings_ff}),
      .den({rings_ff, 1'b0}),
      .quo(phase_t)
   );

   svg_div u_div_p (
      .clock(clock), .advance(advance),
      .num_hi({1'b0, seg0_ff}),
      .num_lo({2'b0, segs_eff[CW-1:1]}),
      .den({1'b0, segs_eff}),
      .quo(phase_p)
   );

   // sine and cosine of both angles
   logic signed [TW-1:0] st, ct, sp, cp;

   svg_cordic u_cordic_t (
      .clock(clock), .advance(advance), .phase(phase_t), .sin_q(st), .cos_q(ct)
   );

   svg_cordic u_cordic_p (
      .clock(clock), .advance(advance), .phase(phase_p), .sin_q(sp), .cos_q(cp)
   );

   // normal products
   logic signed [2*TW-1:0] px_ff, pz_ff;
   logic signed [TW-1:0] ct_ff;
   logic signed [2*TW-1:0] px_r, pz_r;
   logic signed [TW-1:0] n_ff [3];
   logic signed [TW+25-1:0] pm_ff [3];
   logic signed [TW-1:0] nd_ff [3];

   assign px_r = (px_ff + (2*TW)'(64'sd1 <<< 29)) >>> 30;
   assign pz_r = (pz_ff + (2*TW)'(64'sd1 <<< 29)) >>> 30;

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff <= st * sp;
         pz_ff <= st * cp;
         ct_ff <= ct;
         n_ff[0] <= px_r[TW-1:0];
         n_ff[1] <= ct_ff;
         n_ff[2] <= pz_r[TW-1:0];
         for (int k = 0; k < 3; k++) begin
            pm_ff[k] <= n_ff[k] * signed'({1'b0, radius_ff});
            nd_ff[k] <= n_ff[k];
         end
      end
   end

   // final rounding, clamping and pole or error override
   logic signed [POS_W_L-1:0] pos_r [3];
   logic signed [TW-1:0] nrm_r [3];
   logic signed [svg_pkg::POS_W-1:0] pos_c [3];
   logic signed [svg_pkg::NORM_W-1:0] nrm_c [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pos_r[k] = (pm_ff[k] + POS_W_L'(64'sd1 <<< 29)) >>> 30;
         nrm_r[k] = (nd_ff[k] + TW'(33'sd1 <<< (29 - svg_pkg::FRAC_BITS)))
                    >>> (30 - svg_pkg::FRAC_BITS);
         if (pos_r[k] > POS_W_L'(svg_pkg::POS_LIMIT))
            pos_c[k] = svg_pkg::POS_LIMIT;
         else if (pos_r[k] < -POS_W_L'(svg_pkg::POS_LIMIT))
            pos_c[k] = -svg_pkg::POS_LIMIT;
         else
            pos_c[k] = pos_r[k][svg_pkg::POS_W-1:0];
         if (nrm_r[k] > TW'(svg_pkg::NORM_ONE))
            nrm_c[k] = svg_pkg::NORM_ONE;
         else if (nrm_r[k] < -TW'(svg_pkg::NORM_ONE))
            nrm_c[k] = -svg_pkg::NORM_ONE;
         else
            nrm_c[k] = nrm_r[k][svg_pkg::NORM_W-1:0];
      end
   end

   svg_pkg::meta_type mo;
   assign mo = meta_ff[LAT-2];
   logic signed [svg_pkg::POS_W-1:0] rad_s;
   assign rad_s = signed'({1'b0, radius_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_bad_request <= mo.bad;
         if (mo.bad) begin
            rsp_pos_x <= '0; rsp_pos_y <= '0; rsp_pos_z <= '0;
            rsp_norm_x <= '0; rsp_norm_y <= '0; rsp_norm_z <= '0;
         end else if (mo.pole) begin
            rsp_pos_x <= '0; rsp_pos_z <= '0;
            rsp_norm_x <= '0; rsp_norm_z <= '0;
            rsp_pos_y <= mo.south ? -rad_s : rad_s;
            rsp_norm_y <= mo.south ? -svg_pkg::NORM_ONE : svg_pkg::NORM_ONE;
         end else begin
            rsp_pos_x <= pos_c[0]; rsp_pos_y <= pos_c[1]; rsp_pos_z <= pos_c[2];
            rsp_norm_x <= nrm_c[0]; rsp_norm_y <= nrm_c[1]; rsp_norm_z <= nrm_c[2];
         end
      end
   end

   assign rsp_valid = vld_ff[LAT-1];

`ifndef SYNTH
   // accepted requests enter the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted request did not enter pipeline");
   // error responses carry no geometry
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_request) |->
      (rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_pos_z == '0 &&
       rsp_norm_x == '0 && rsp_norm_y == '0 && rsp_norm_z == '0))
      else $error("bad request with nonzero fields");
   // x and y normals stay within unit range
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_norm_y <= svg_pkg::NORM_ONE &&
                     rsp_norm_y >= -svg_pkg::NORM_ONE &&
                     rsp_norm_x <= svg_pkg::NORM_ONE &&
                     rsp_norm_x >= -svg_pkg::NORM_ONE))
      else $error("normal out of range");
   // a stalled response freezes the input side
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input accepted while output held");
`endif
endmodule
